// ----- rtl/crsd_pkg.sv -----
`timescale 1ns / 1ps

package crsd_pkg;

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned CHAN_BITS  = 8;
  localparam int unsigned RUN_BITS   = 11;

  localparam logic [RUN_BITS-1:0]   RUN_MAX    = {RUN_BITS{1'b1}};
  localparam logic [CHAN_BITS-1:0]  EDGE_DIFF  = CHAN_BITS'(50);
  localparam logic [CHAN_BITS-1:0]  DARK_LIMIT = CHAN_BITS'(155);
  localparam logic [COORD_BITS-1:0] EDGE_MIN_COL = COORD_BITS'(1);

  localparam logic [CHAN_BITS-1:0] RED_THR_RST   = CHAN_BITS'(200);
  localparam logic [CHAN_BITS-1:0] GREEN_THR_RST = CHAN_BITS'(170);
  localparam logic [CHAN_BITS-1:0] BLUE_THR_RST  = CHAN_BITS'(170);
  localparam logic [RUN_BITS-1:0]  MIN_RUN_RST   = RUN_BITS'(10);

  localparam int unsigned CFG_DATA_BITS = RUN_BITS;

  typedef enum logic [1:0] {
    CfgRedThr   = 2'd0,
    CfgGreenThr = 2'd1,
    CfgBlueThr  = 2'd2,
    CfgMinRun   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KindRun  = 1'b0,
    KindEdge = 1'b1
  } seg_kind_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [CHAN_BITS-1:0]  red;
    logic [CHAN_BITS-1:0]  green;
    logic [CHAN_BITS-1:0]  blue;
    logic                  column_start;
  } pix_in_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_col;
    logic [COORD_BITS-1:0] start_row;
    logic [COORD_BITS-1:0] end_col;
    logic [COORD_BITS-1:0] end_row;
    logic                  last;
  } seg_out_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red_thr;
    logic [CHAN_BITS-1:0] green_thr;
    logic [CHAN_BITS-1:0] blue_thr;
    logic [RUN_BITS-1:0]  min_run;
  } cfg_t;

  // results caused by one pixel, edge result delivered first
  typedef struct packed {
    logic     edge_vld;
    logic     run_vld;
    seg_out_t edge_res;
    seg_out_t run_res;
  } res_pair_t;

endpackage

// ----- rtl/column_run_segment_detector.sv -----
`timescale 1ns / 1ps

// Column run and segment detector.
// Input channel: in_valid_i / in_stall_o / in_data_i carries one RGB pixel per
// request, column-major, with column_start set on the first pixel of a column.
// Output channel: out_valid_o / out_stall_i / out_data_o carries one segment
// per request; a pixel yields zero, one or two segments (edge before run), and
// the last one it yields has last set.
// Configuration: cfg_we_i writes cfg_wdata_i into the threshold or minimum run
// register chosen by cfg_idx_i; only write while the block is idle.
// A pixel taken is held in the input register and evaluated there; its
// segments enter the queue once the queue has room for two, and the queue's
// head drives the output, so a full queue can hold the pixel in between.
// Throughput: one pixel per cycle while the queue has room; the rate is set by
// the output port, which moves one segment per cycle when not stalled, so
// pixels that yield two segments use the output port for each of them.
// A four-entry result queue separates the two sides; in_stall_o rises when the
// queue cannot take two more segments and a pixel is waiting.
// Reset clears all detector state, loads the default register values and
// empties the queue. An output stall holds the head segment stable.
module column_run_segment_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  crsd_pkg::pix_in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output crsd_pkg::seg_out_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  crsd_pkg::cfg_idx_e                    cfg_idx_i,
  input  logic [crsd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);
  import crsd_pkg::*;

  cfg_t      cfg_q;
  pix_in_t   pix_q;
  logic      pix_vld_q, pix_vld_d;
  logic      room, step, in_acc;
  res_pair_t pair;

  assign step       = pix_vld_q && room;
  assign in_stall_o = pix_vld_q && !room;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    pix_vld_d = pix_vld_q;
    if (in_acc) begin
      pix_vld_d = 1'b1;
    end else if (step) begin
      pix_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q       <= 1'b0;
      cfg_q.red_thr   <= RED_THR_RST;
      cfg_q.green_thr <= GREEN_THR_RST;
      cfg_q.blue_thr  <= BLUE_THR_RST;
      cfg_q.min_run   <= MIN_RUN_RST;
    end else begin
      pix_vld_q <= pix_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRedThr:   cfg_q.red_thr   <= cfg_wdata_i[CHAN_BITS-1:0];
          CfgGreenThr: cfg_q.green_thr <= cfg_wdata_i[CHAN_BITS-1:0];
          CfgBlueThr:  cfg_q.blue_thr  <= cfg_wdata_i[CHAN_BITS-1:0];
          CfgMinRun:   cfg_q.min_run   <= cfg_wdata_i[RUN_BITS-1:0];
          default:     ;
        endcase
      end
    end
  end

  crsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pix_i  (pix_q),
    .cfg_i  (cfg_q),
    .res_o  (pair)
  );

  crsd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .pair_i      (pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/crsd_core.sv -----
`timescale 1ns / 1ps

module crsd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  crsd_pkg::pix_in_t  pix_i,
  input  crsd_pkg::cfg_t     cfg_i,
  output crsd_pkg::res_pair_t res_o
);
  import crsd_pkg::*;

  logic [RUN_BITS-1:0]   run_len_q, run_len_d;
  logic [COORD_BITS-1:0] run_col_q, run_col_d;
  logic [COORD_BITS-1:0] run_row_q, run_row_d;
  logic [CHAN_BITS-1:0]  ref_r_q, ref_r_d;
  logic [CHAN_BITS-1:0]  ref_g_q, ref_g_d;
  logic [CHAN_BITS-1:0]  ref_b_q, ref_b_d;
  logic                  ref_vld_q, ref_vld_d;
  logic                  reload_q, reload_d;
  logic                  edge_open_q, edge_open_d;
  logic [COORD_BITS-1:0] edge_col_q, edge_col_d;
  logic [COORD_BITS-1:0] edge_row_q, edge_row_d;

  // state as seen after a column start clears it
  logic [RUN_BITS-1:0]   run_len_c;
  logic [COORD_BITS-1:0] run_col_c, run_row_c;
  logic                  ref_vld_c, reload_c, edge_open_c;

  logic [CHAN_BITS-1:0] dr, dg, db;
  logic                 all_near, all_far, dark, bright;

  always_comb begin
    dr = (ref_r_q > pix_i.red)   ? ref_r_q - pix_i.red   : pix_i.red   - ref_r_q;
    dg = (ref_g_q > pix_i.green) ? ref_g_q - pix_i.green : pix_i.green - ref_g_q;
    db = (ref_b_q > pix_i.blue)  ? ref_b_q - pix_i.blue  : pix_i.blue  - ref_b_q;
    all_near = (dr < EDGE_DIFF) && (dg < EDGE_DIFF) && (db < EDGE_DIFF);
    all_far  = (dr > EDGE_DIFF) && (dg > EDGE_DIFF) && (db > EDGE_DIFF);
    dark     = (pix_i.red < DARK_LIMIT) && (pix_i.green < DARK_LIMIT) &&
               (pix_i.blue < DARK_LIMIT);
    bright   = (pix_i.red > cfg_i.red_thr) && (pix_i.green > cfg_i.green_thr) &&
               (pix_i.blue > cfg_i.blue_thr);
  end

  always_comb begin
    run_len_c   = pix_i.column_start ? '0   : run_len_q;
    run_col_c   = pix_i.column_start ? '0   : run_col_q;
    run_row_c   = pix_i.column_start ? '0   : run_row_q;
    ref_vld_c   = pix_i.column_start ? 1'b0 : ref_vld_q;
    reload_c    = pix_i.column_start ? 1'b1 : reload_q;
    edge_open_c = pix_i.column_start ? 1'b0 : edge_open_q;

    ref_r_d     = ref_r_q;
    ref_g_d     = ref_g_q;
    ref_b_d     = ref_b_q;
    ref_vld_d   = ref_vld_c;
    reload_d    = reload_c;
    edge_open_d = edge_open_c;
    edge_col_d  = edge_col_q;
    edge_row_d  = edge_row_q;

    res_o.edge_vld           = 1'b0;
    res_o.edge_res.kind      = KindEdge;
    res_o.edge_res.start_col = edge_col_q;
    res_o.edge_res.start_row = edge_row_q;
    res_o.edge_res.end_col   = pix_i.col;
    res_o.edge_res.end_row   = pix_i.row - COORD_BITS'(1);

    // color-edge detector
    if (!ref_vld_c || reload_c) begin
      reload_d   = 1'b0;
      edge_col_d = pix_i.col;
      edge_row_d = pix_i.row;
      if (!ref_vld_c || all_near) begin
        ref_r_d   = pix_i.red;
        ref_g_d   = pix_i.green;
        ref_b_d   = pix_i.blue;
        ref_vld_d = 1'b1;
      end
      edge_open_d = 1'b0;
    end else if (all_far) begin
      if (edge_open_c) begin
        res_o.edge_vld = (pix_i.col > EDGE_MIN_COL) && dark;
        edge_open_d    = 1'b0;
        reload_d       = 1'b1;
      end else begin
        edge_open_d = 1'b1;
        edge_col_d  = pix_i.col;
        edge_row_d  = pix_i.row;
        ref_r_d     = pix_i.red;
        ref_g_d     = pix_i.green;
        ref_b_d     = pix_i.blue;
      end
    end else if (!edge_open_c) begin
      reload_d = 1'b1;
    end

    // bright-run detector
    res_o.run_vld           = 1'b0;
    res_o.run_res.kind      = KindRun;
    res_o.run_res.start_col = run_col_c;
    res_o.run_res.start_row = run_row_c;
    res_o.run_res.end_col   = pix_i.col;
    res_o.run_res.end_row   = pix_i.row;
    res_o.run_res.last      = 1'b1;
    run_len_d = run_len_c;
    run_col_d = run_col_c;
    run_row_d = run_row_c;
    if (bright) begin
      if (run_len_c == '0) begin
        run_col_d = pix_i.col;
        run_row_d = pix_i.row;
      end
      if (run_len_c != RUN_MAX) begin
        run_len_d = run_len_c + RUN_BITS'(1);
      end
    end else begin
      res_o.run_vld = run_len_c > cfg_i.min_run;
      run_len_d     = '0;
      run_col_d     = '0;
      run_row_d     = '0;
    end

    res_o.edge_res.last = !res_o.run_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q   <= '0;
      run_col_q   <= '0;
      run_row_q   <= '0;
      ref_r_q     <= '0;
      ref_g_q     <= '0;
      ref_b_q     <= '0;
      ref_vld_q   <= 1'b0;
      reload_q    <= 1'b1;
      edge_open_q <= 1'b0;
      edge_col_q  <= '0;
      edge_row_q  <= '0;
    end else if (step_i) begin
      run_len_q   <= run_len_d;
      run_col_q   <= run_col_d;
      run_row_q   <= run_row_d;
      ref_r_q     <= ref_r_d;
      ref_g_q     <= ref_g_d;
      ref_b_q     <= ref_b_d;
      ref_vld_q   <= ref_vld_d;
      reload_q    <= reload_d;
      edge_open_q <= edge_open_d;
      edge_col_q  <= edge_col_d;
      edge_row_q  <= edge_row_d;
    end
  end

endmodule

// ----- rtl/crsd_outq.sv -----
`timescale 1ns / 1ps

module crsd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crsd_pkg::res_pair_t pair_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crsd_pkg::seg_out_t  out_data_o
);
  import crsd_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  seg_out_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic              wr_one, wr_two;
  seg_out_t          first_res;
  logic [PtrW-1:0]   wr_ptr_nx;

  assign wr_one    = push_i && (pair_i.edge_vld || pair_i.run_vld);
  assign wr_two    = push_i && pair_i.edge_vld && pair_i.run_vld;
  assign first_res = pair_i.edge_vld ? pair_i.edge_res : pair_i.run_res;
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  // room for the two results a pixel may cause
  assign room_o      = cnt_q <= CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (wr_two) begin
      wr_ptr_d = wr_ptr_q + PtrW'(2);
    end else if (wr_one) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(wr_one) + CntW'(wr_two) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_one) begin
      mem_q[wr_ptr_q] <= first_res;
    end
    if (wr_two) begin
      mem_q[wr_ptr_nx] <= pair_i.run_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- tb/column_run_segment_detector_tb.sv -----
`timescale 1ns / 1ps

// Predicts the segments of the detector and checks them in order.
class segment_scoreboard;
  logic [crsd_pkg::CHAN_BITS-1:0]  red_thr, green_thr, blue_thr;
  logic [crsd_pkg::RUN_BITS-1:0]   min_run;
  logic [crsd_pkg::RUN_BITS-1:0]   run_len;
  logic [crsd_pkg::COORD_BITS-1:0] run_col, run_row;
  logic [crsd_pkg::CHAN_BITS-1:0]  ref_r, ref_g, ref_b;
  bit                              ref_valid, reload_ref, edge_open;
  logic [crsd_pkg::COORD_BITS-1:0] edge_col, edge_row;
  crsd_pkg::seg_out_t              expected_segs[$];
  int                              mismatches;

  function new();
    red_thr    = crsd_pkg::RED_THR_RST;
    green_thr  = crsd_pkg::GREEN_THR_RST;
    blue_thr   = crsd_pkg::BLUE_THR_RST;
    min_run    = crsd_pkg::MIN_RUN_RST;
    run_len    = '0;
    run_col    = '0;
    run_row    = '0;
    ref_r      = '0;
    ref_g      = '0;
    ref_b      = '0;
    ref_valid  = 1'b0;
    reload_ref = 1'b1;
    edge_open  = 1'b0;
    edge_col   = '0;
    edge_row   = '0;
    mismatches = 0;
  endfunction

  function void write_reg(crsd_pkg::cfg_idx_e idx, logic [crsd_pkg::CFG_DATA_BITS-1:0] v);
    case (idx)
      crsd_pkg::CfgRedThr:   red_thr   = v[crsd_pkg::CHAN_BITS-1:0];
      crsd_pkg::CfgGreenThr: green_thr = v[crsd_pkg::CHAN_BITS-1:0];
      crsd_pkg::CfgBlueThr:  blue_thr  = v[crsd_pkg::CHAN_BITS-1:0];
      crsd_pkg::CfgMinRun:   min_run   = v[crsd_pkg::RUN_BITS-1:0];
      default: ;
    endcase
  endfunction

  function logic [crsd_pkg::CHAN_BITS-1:0] chan_dist(logic [crsd_pkg::CHAN_BITS-1:0] a,
                                                     logic [crsd_pkg::CHAN_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function void note_pixel(crsd_pkg::pix_in_t p);
    crsd_pkg::seg_out_t              segs[$];
    crsd_pkg::seg_out_t              s;
    logic [crsd_pkg::CHAN_BITS-1:0]  dr, dg, db;
    if (p.column_start) begin
      run_len    = '0;
      run_col    = '0;
      run_row    = '0;
      ref_valid  = 1'b0;
      reload_ref = 1'b1;
      edge_open  = 1'b0;
    end
    dr = chan_dist(ref_r, p.red);
    dg = chan_dist(ref_g, p.green);
    db = chan_dist(ref_b, p.blue);

    // color edge tracking
    if (!ref_valid || reload_ref) begin
      reload_ref = 1'b0;
      edge_col   = p.col;
      edge_row   = p.row;
      if (!ref_valid || (dr < crsd_pkg::EDGE_DIFF && dg < crsd_pkg::EDGE_DIFF &&
                         db < crsd_pkg::EDGE_DIFF)) begin
        ref_r     = p.red;
        ref_g     = p.green;
        ref_b     = p.blue;
        ref_valid = 1'b1;
      end
      edge_open = 1'b0;
    end else if (dr > crsd_pkg::EDGE_DIFF && dg > crsd_pkg::EDGE_DIFF &&
                 db > crsd_pkg::EDGE_DIFF) begin
      if (edge_open) begin
        if (p.col > crsd_pkg::EDGE_MIN_COL && p.red < crsd_pkg::DARK_LIMIT &&
            p.green < crsd_pkg::DARK_LIMIT && p.blue < crsd_pkg::DARK_LIMIT) begin
          s.kind      = crsd_pkg::KindEdge;
          s.start_col = edge_col;
          s.start_row = edge_row;
          s.end_col   = p.col;
          s.end_row   = p.row - crsd_pkg::COORD_BITS'(1);
          s.last      = 1'b0;
          segs        = {segs, s};
        end
        edge_open  = 1'b0;
        reload_ref = 1'b1;
      end else begin
        edge_open = 1'b1;
        edge_col  = p.col;
        edge_row  = p.row;
        ref_r     = p.red;
        ref_g     = p.green;
        ref_b     = p.blue;
      end
    end else if (!edge_open) begin
      reload_ref = 1'b1;
    end

    // bright run tracking, length saturates
    if (p.red > red_thr && p.green > green_thr && p.blue > blue_thr) begin
      if (run_len == '0) begin
        run_col = p.col;
        run_row = p.row;
      end
      if (run_len < crsd_pkg::RUN_MAX) run_len++;
    end else begin
      if (run_len > min_run) begin
        s.kind      = crsd_pkg::KindRun;
        s.start_col = run_col;
        s.start_row = run_row;
        s.end_col   = p.col;
        s.end_row   = p.row;
        s.last      = 1'b0;
        segs        = {segs, s};
      end
      run_len = '0;
      run_col = '0;
      run_row = '0;
    end

    if (segs.size() > 0) segs[segs.size()-1].last = 1'b1;
    foreach (segs[i]) expected_segs = {expected_segs, segs[i]};
  endfunction

  function string fmt(crsd_pkg::seg_out_t s);
    return $sformatf("kind=%0d start=(%0d,%0d) end=(%0d,%0d) last=%0d",
                     s.kind, s.start_col, s.start_row, s.end_col, s.end_row, s.last);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function void check_segment(crsd_pkg::seg_out_t got);
    crsd_pkg::seg_out_t want;
    if (expected_segs.size() == 0) begin
      flag({"unexpected segment ", fmt(got)});
      return;
    end
    want = expected_segs.pop_front();
    if (got.kind !== want.kind || got.start_col !== want.start_col ||
        got.start_row !== want.start_row || got.end_col !== want.end_col ||
        got.end_row !== want.end_row || got.last !== want.last)
      flag({"expected ", fmt(want), " got ", fmt(got)});
  endfunction

  function int pending();
    return expected_segs.size();
  endfunction
endclass

module column_run_segment_detector_tb;
  import crsd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;

  typedef enum int {ShadeBright, ShadeMid, ShadeDark, ShadeNoise} shade_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  pix_in_t                  in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  seg_out_t                 out_data_o;
  logic                     cfg_we_i    = 1'b0;
  cfg_idx_e                 cfg_idx_i   = CfgRedThr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  int                       in_idle_pct  = 17;
  int                       out_idle_pct = 17;
  int                       quiet_cycles = 0;
  int                       pixels_sent  = 0;
  logic [COORD_BITS-1:0]    scan_col     = '0;
  segment_scoreboard        sb;

  column_run_segment_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_segment(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("column_run_segment_detector_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic pix_in_t make_pixel(int col, int row, int r, int g, int b, bit cs);
    pix_in_t p;
    p.col          = COORD_BITS'(col);
    p.row          = COORD_BITS'(row);
    p.red          = CHAN_BITS'(r);
    p.green        = CHAN_BITS'(g);
    p.blue         = CHAN_BITS'(b);
    p.column_start = cs;
    return p;
  endfunction

  function automatic int shade_value(shade_e shade, int base);
    int v;
    if (shade == ShadeNoise) return $urandom_range(255);
    v = base + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  task automatic send_pixel(input pix_in_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_noise();
    send_pixel(make_pixel($urandom_range(2047), $urandom_range(2047), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), 1'($urandom_range(1))));
  endtask

  // sender holds off until every predicted segment is out, then lets the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_DATA_BITS-1:0] r, logic [CFG_DATA_BITS-1:0] g,
                            logic [CFG_DATA_BITS-1:0] b, logic [CFG_DATA_BITS-1:0] m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgRedThr;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    sb.write_reg(CfgRedThr, r);
    cfg_idx_i   <= CfgGreenThr;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    sb.write_reg(CfgGreenThr, g);
    cfg_idx_i   <= CfgBlueThr;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    sb.write_reg(CfgBlueThr, b);
    cfg_idx_i   <= CfgMinRun;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    sb.write_reg(CfgMinRun, m);
    cfg_we_i    <= 1'b0;
  endtask

  // one column of flat-colored stretches: bright, mid, dark or noisy
  task automatic send_scene_column(int height);
    int     row_base;
    int     seg_left;
    int     base[3];
    shade_e shade;
    seg_left = 0;
    shade    = ShadeMid;
    row_base = ($urandom_range(3) == 0) ? int'($urandom_range(2047)) : 0;
    for (int row = 0; row < height; row++) begin
      if (seg_left == 0) begin
        shade    = shade_e'($urandom_range(3));
        seg_left = (shade == ShadeBright) ? $urandom_range(1, 24) : $urandom_range(1, 10);
        for (int c = 0; c < 3; c++) begin
          case (shade)
            ShadeBright: base[c] = $urandom_range(215, 247);
            ShadeMid:    base[c] = $urandom_range(100, 150);
            ShadeDark:   base[c] = $urandom_range(0, 45);
            default:     base[c] = 0;
          endcase
        end
      end
      seg_left--;
      send_pixel(make_pixel(int'(scan_col), row_base + row, shade_value(shade, base[0]),
                            shade_value(shade, base[1]), shade_value(shade, base[2]),
                            row == 0));
      if ($urandom_range(99) < 3) send_noise();
    end
    scan_col++;
  endtask

  task automatic run_phase(int count);
    int  target;
    bit  paused;
    target   = pixels_sent + count;
    paused   = 1'b0;
    scan_col = COORD_BITS'($urandom_range(2047));
    while (pixels_sent < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) send_noise();
      end else begin
        send_scene_column($urandom_range(1, 40));
      end
      if (!paused && pixels_sent >= target - count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge closing at a low column gives nothing
    send_pixel(make_pixel(0, 0, 128, 128, 128, 1'b1));
    send_pixel(make_pixel(0, 1, 250, 250, 250, 1'b0));
    send_pixel(make_pixel(0, 2, 10, 10, 10, 1'b0));
    // edge and run both end on one dark pixel
    send_pixel(make_pixel(2, 0, 130, 130, 130, 1'b1));
    send_pixel(make_pixel(2, 1, 255, 255, 255, 1'b0));
    for (int row = 2; row <= 12; row++) send_pixel(make_pixel(2, row, 250, 250, 250, 1'b0));
    send_pixel(make_pixel(2, 13, 0, 0, 0, 1'b0));
    // edge closing on row zero wraps its end row; then a reload that keeps the reference
    send_pixel(make_pixel(3, 5, 128, 128, 128, 1'b1));
    send_pixel(make_pixel(3, 6, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(3, 0, 90, 90, 90, 1'b0));
    send_pixel(make_pixel(3, 1, 200, 10, 90, 1'b0));
    // open edge dropped by a column start
    send_pixel(make_pixel(4, 0, 128, 128, 128, 1'b1));
    send_pixel(make_pixel(4, 1, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(5, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(2047, 2047, 255, 0, 255, 1'b1));
    send_pixel(make_pixel(2047, 0, 0, 255, 0, 1'b0));

    run_phase(175);

    // zero thresholds, upper write bits must be dropped; no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(11'h700, 11'h600, 11'h500, 11'd0);
    run_phase(175);
    in_idle_pct  = 17;
    out_idle_pct = 17;

    set_config(11'd255, 11'd255, 11'd255, 11'd2047);
    run_phase(175);

    set_config(CFG_DATA_BITS'($urandom_range(150, 240)),
               CFG_DATA_BITS'($urandom_range(150, 240)),
               CFG_DATA_BITS'($urandom_range(150, 240)),
               CFG_DATA_BITS'($urandom_range(0, 6)));
    run_phase(175);

    wait_drained();
    if (sb.pending() != 0) sb.flag($sformatf("%0d segments never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("column_run_segment_detector_tb: done, clean");
    end else begin
      $display("column_run_segment_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
